[src/ccls_pkg.sv]
`timescale 1ns / 1ps
// ccls_pkg: shared types, op codes and the default connection set
// for the can id range classifier; no dependencies
package ccls_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int DFLT_COUNT      = 17;
    localparam int INDEX_W         = 5;
    localparam int COUNT_W         = 6;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_FIND_SVC = 2'd1,
        OP_FIND_ID  = 2'd2,
        OP_CLEAR    = 2'd3
    } op_e;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_e;

    typedef struct packed {
        op_e         op;
        logic [3:0]  service;
        logic        direction;
        logic [10:0] cob_id;
        logic [11:0] span;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] entry_count;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic [3:0]  service;
        logic        direction;
        logic [10:0] base;
        logic [11:0] span;
    } entry_t;

    function automatic entry_t dflt_entry(input logic [4:0] idx);
        entry_t e;
        case (idx)
            5'd0:    e = '{4'd0,  1'b1, 11'h000, 12'd1};
            5'd1:    e = '{4'd1,  1'b1, 11'h080, 12'd1};
            5'd2:    e = '{4'd2,  1'b0, 11'h080, 12'd128};
            5'd3:    e = '{4'd3,  1'b1, 11'h100, 12'd1};
            5'd4:    e = '{4'd4,  1'b0, 11'h180, 12'd128};
            5'd5:    e = '{4'd4,  1'b1, 11'h200, 12'd128};
            5'd6:    e = '{4'd5,  1'b0, 11'h280, 12'd128};
            5'd7:    e = '{4'd5,  1'b1, 11'h300, 12'd128};
            5'd8:    e = '{4'd6,  1'b0, 11'h380, 12'd128};
            5'd9:    e = '{4'd6,  1'b1, 11'h400, 12'd128};
            5'd10:   e = '{4'd7,  1'b0, 11'h480, 12'd128};
            5'd11:   e = '{4'd7,  1'b1, 11'h500, 12'd128};
            5'd12:   e = '{4'd8,  1'b0, 11'h580, 12'd128};
            5'd13:   e = '{4'd8,  1'b1, 11'h600, 12'd128};
            5'd14:   e = '{4'd9,  1'b0, 11'h700, 12'd128};
            5'd15:   e = '{4'd10, 1'b0, 11'h7e4, 12'd1};
            5'd16:   e = '{4'd10, 1'b1, 11'h7e5, 12'd1};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

[src/ccls_entry_store.sv]
`timescale 1ns / 1ps
// ccls_entry_store: connection table memory, one write and one registered read
// port; default set overlays the low entries until the first clear; uses ccls_pkg
module ccls_entry_store
    import ccls_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  entry_t                         wr_entry,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic                           dflt_live,
    output entry_t                         rd_entry
);

    localparam int AW = $clog2(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (dflt_live && (rd_addr < AW'(DFLT_COUNT)))
            begin
                rd_entry_reg <= dflt_entry(rd_addr[4:0]);
            end
            else
            begin
                rd_entry_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

[src/ccls_match_unit.sv]
`timescale 1ns / 1ps
// ccls_match_unit: shared compare unit, service/direction equality or
// identifier range test with an unwrapped range end; uses ccls_pkg
module ccls_match_unit
    import ccls_pkg::*;
(
    input  op_e         mode,
    input  logic [3:0]  service,
    input  logic        direction,
    input  logic [10:0] cob_id,
    input  entry_t      entry,
    output logic        hit
);

    logic [12:0] range_end;
    logic        svc_hit;
    logic        id_hit;

    assign range_end = {2'b00, entry.base} + {1'b0, entry.span};
    assign svc_hit   = (entry.service == service) && (entry.direction == direction);
    assign id_hit    = (cob_id >= entry.base) && ({2'b00, cob_id} < range_end);

    always_comb
    begin
        case (mode)
            OP_FIND_SVC: hit = svc_hit;
            OP_FIND_ID:  hit = id_hit;
            default:     hit = 1'b0;
        endcase
    end

endmodule

[src/can_id_range_classifier_unit.sv]
`timescale 1ns / 1ps
// can_id_range_classifier_unit: top level, command sequencer around the entry
// table and the shared compare unit; uses ccls_pkg, ccls_entry_store, ccls_match_unit
//
// A word is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and must be taken then. Append
// and clear finish at once: done rises in the cycle after the accept and busy
// never rises, so a new word may follow in the next cycle. Searches walk the
// held entries one per cycle through the table's single read port and the one
// compare unit: busy stays high until a hit or until every held entry has been
// compared, and done comes in the first cycle with busy low. Reset loads the
// 17-entry default set at once, with no clearing pass.
module can_id_range_classifier_unit
    import ccls_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd,
    output logic      done,
    output out_word_t result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_e          state_reg,     state_next;
    logic [CW-1:0]   held_reg,      held_next;
    logic            dflt_live_reg, dflt_live_next;
    logic [CW-1:0]   addr_reg,      addr_next;
    logic            rd_valid_reg,  rd_valid_next;
    logic [AW-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic            done_reg,      done_next;
    in_word_t        cmd_reg,       cmd_next;
    out_word_t       result_reg,    result_next;

    logic            accept;
    logic            issue;
    logic            hit;
    logic            finish_hit;
    logic            finish_miss;
    logic            wr_en;
    entry_t          wr_entry;
    entry_t          rd_entry;

    assign accept      = start && (state_reg == S_IDLE);
    assign issue       = (state_reg == S_SCAN) && (addr_reg < held_reg);
    assign finish_hit  = (state_reg == S_SCAN) && rd_valid_reg && hit;
    assign finish_miss = (state_reg == S_SCAN) && !rd_valid_reg && (addr_reg == held_reg);
    assign wr_en       = accept && (cmd.op == OP_APPEND) && (held_reg < CW'(TABLE_DEPTH));
    assign wr_entry    = '{cmd.service, cmd.direction, cmd.cob_id, cmd.span};

    ccls_entry_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (held_reg[AW-1:0]),
        .wr_entry  (wr_entry),
        .rd_en     (issue),
        .rd_addr   (addr_reg[AW-1:0]),
        .dflt_live (dflt_live_reg),
        .rd_entry  (rd_entry)
    );

    ccls_match_unit u_match (
        .mode      (cmd_reg.op),
        .service   (cmd_reg.service),
        .direction (cmd_reg.direction),
        .cob_id    (cmd_reg.cob_id),
        .entry     (rd_entry),
        .hit       (hit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && ((cmd.op == OP_FIND_SVC) || (cmd.op == OP_FIND_ID)))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (finish_hit || finish_miss)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        held_next      = held_reg;
        dflt_live_next = dflt_live_reg;
        addr_next      = addr_reg;
        rd_valid_next  = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        done_next      = 1'b0;
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd;
                    addr_next = '0;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (wr_en)
                            begin
                                held_next   = held_reg + 1'b1;
                                result_next = '{1'b1, INDEX_W'(held_reg),
                                                COUNT_W'(held_reg + 1'b1), 1'b0};
                            end
                            else
                            begin
                                result_next = '{1'b0, '0, COUNT_W'(held_reg), 1'b1};
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next      = 1'b1;
                            held_next      = '0;
                            dflt_live_next = 1'b0;
                            result_next    = '{1'b0, '0, '0, 1'b0};
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (finish_hit)
                begin
                    done_next   = 1'b1;
                    result_next = '{1'b1, INDEX_W'(cmp_idx_reg), COUNT_W'(held_reg), 1'b0};
                end
                else if (finish_miss)
                begin
                    done_next   = 1'b1;
                    result_next = '{1'b0, '0, COUNT_W'(held_reg), 1'b0};
                end
                else if (issue)
                begin
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = addr_reg[AW-1:0];
                    addr_next     = addr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= CW'(DFLT_COUNT);
            dflt_live_reg <= 1'b1;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            dflt_live_reg <= dflt_live_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= rd_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        cmd_reg     <= cmd_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_addr : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (addr_reg <= held_reg))
        else $error("scan address past held entries");

    a_rd_valid_scan : assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_SCAN))
        else $error("read data pending outside scan");

    a_hit_result : assert property (@(posedge clk) disable iff (!rst_n)
        finish_hit |=> (done && result.found && !busy))
        else $error("hit not reported");

    a_ovf_excl : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> !result.found)
        else $error("overflow together with found");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for can_id_range_classifier_unit, directed then random
// commands against an in-bench table predictor; uses ccls_pkg and the rtl under src
module tb;
    import ccls_pkg::*;

    localparam int ROWS       = TABLE_DEPTH_DEF;
    localparam int RAND_WORDS = 1520;
    localparam int QUIET_TAIL = 150;
    localparam int SETTLE     = 40;

    localparam logic [3:0] SVC_NMT  = 4'd0;
    localparam logic [3:0] SVC_SYNC = 4'd1;
    localparam logic [3:0] SVC_SDO  = 4'd8;
    localparam logic [3:0] SVC_LSS  = 4'd10;
    localparam logic [3:0] SVC_TOP  = 4'd15;
    localparam logic       DIR_TX   = 1'b0;
    localparam logic       DIR_RX   = 1'b1;

    typedef struct {
        in_word_t word;
        bit       no_gap;
        bit       drain;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  cmd = '0;
    logic      busy;
    logic      done;
    out_word_t result;

    can_id_range_classifier_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // predicted table contents
    entry_t    conn_rows [ROWS];
    int        conn_held;

    pending_t  pending [$];
    out_word_t expected [$];
    int        near_ids [$];
    int        words_total = 0;
    int        words_taken = 0;
    int        mismatches = 0;
    bit        quiet = 1'b0;
    logic      taken = 1'b0;
    int        gap_left = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void load_default_set();
        for (int i = 0; i < ROWS; i++)
            conn_rows[i] = '0;
        conn_rows[0]  = '{SVC_NMT,  DIR_RX, 11'h000, 12'd1};
        conn_rows[1]  = '{SVC_SYNC, DIR_RX, 11'h080, 12'd1};
        conn_rows[2]  = '{4'd2,     DIR_TX, 11'h080, 12'd128};
        conn_rows[3]  = '{4'd3,     DIR_RX, 11'h100, 12'd1};
        conn_rows[4]  = '{4'd4,     DIR_TX, 11'h180, 12'd128};
        conn_rows[5]  = '{4'd4,     DIR_RX, 11'h200, 12'd128};
        conn_rows[6]  = '{4'd5,     DIR_TX, 11'h280, 12'd128};
        conn_rows[7]  = '{4'd5,     DIR_RX, 11'h300, 12'd128};
        conn_rows[8]  = '{4'd6,     DIR_TX, 11'h380, 12'd128};
        conn_rows[9]  = '{4'd6,     DIR_RX, 11'h400, 12'd128};
        conn_rows[10] = '{4'd7,     DIR_TX, 11'h480, 12'd128};
        conn_rows[11] = '{4'd7,     DIR_RX, 11'h500, 12'd128};
        conn_rows[12] = '{SVC_SDO,  DIR_TX, 11'h580, 12'd128};
        conn_rows[13] = '{SVC_SDO,  DIR_RX, 11'h600, 12'd128};
        conn_rows[14] = '{4'd9,     DIR_TX, 11'h700, 12'd128};
        conn_rows[15] = '{SVC_LSS,  DIR_TX, 11'h7e4, 12'd1};
        conn_rows[16] = '{SVC_LSS,  DIR_RX, 11'h7e5, 12'd1};
        conn_held = 17;
    endfunction

    function automatic out_word_t classify_word(input in_word_t w);
        out_word_t r;
        int lo;
        int hi;
        r = '0;
        case (w.op)
            OP_APPEND:
            begin
                if (conn_held >= ROWS)
                    r.overflow = 1'b1;
                else
                begin
                    conn_rows[conn_held] = '{w.service, w.direction, w.cob_id, w.span};
                    r.found = 1'b1;
                    r.index = conn_held[INDEX_W-1:0];
                    conn_held++;
                end
            end
            OP_FIND_SVC:
            begin
                for (int i = 0; i < conn_held; i++)
                begin
                    if (!r.found && conn_rows[i].service == w.service
                        && conn_rows[i].direction == w.direction)
                    begin
                        r.found = 1'b1;
                        r.index = i[INDEX_W-1:0];
                    end
                end
            end
            OP_FIND_ID:
            begin
                for (int i = 0; i < conn_held; i++)
                begin
                    lo = int'(conn_rows[i].base);
                    hi = lo + int'(conn_rows[i].span);
                    if (!r.found && int'(w.cob_id) >= lo && int'(w.cob_id) < hi)
                    begin
                        r.found = 1'b1;
                        r.index = i[INDEX_W-1:0];
                    end
                end
            end
            default:
                conn_held = 0;
        endcase
        r.entry_count = conn_held[COUNT_W-1:0];
        return r;
    endfunction

    task automatic queue_word(input op_e op, input logic [3:0] svc, input logic dir,
                              input int id, input int span, input bit drain);
        pending_t p;
        p.word.op        = op;
        p.word.service   = svc;
        p.word.direction = dir;
        p.word.cob_id    = id[10:0];
        p.word.span      = span[11:0];
        p.no_gap         = quiet;
        p.drain          = drain;
        pending.push_back(p);
        words_total++;
    endtask

    function automatic int pick_span();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 128;
            3: return 2048;
            4: return $urandom_range(2049, 4095);
            5: return 4095;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic int pick_base();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 2047;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    task automatic note_range(input int base, input int span);
        int marks [4];
        marks = '{base - 1, base, base + span - 1, base + span};
        foreach (marks[i])
            if (marks[i] >= 0 && marks[i] <= 2047)
                near_ids.push_back(marks[i]);
        while (near_ids.size() > 64)
            void'(near_ids.pop_front());
    endtask

    task automatic queue_random_word(input int app_pct, input bit drain);
        int r;
        int base;
        int span;
        int id;
        logic [3:0] svc;
        r = $urandom_range(0, 99);
        if (r < 2)
            queue_word(OP_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 2047), $urandom_range(0, 4095), drain);
        else if (r < 2 + app_pct)
        begin
            base = pick_base();
            span = pick_span();
            note_range(base, span);
            queue_word(OP_APPEND, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       base, span, drain);
        end
        else if (r < 2 + app_pct + (98 - app_pct) / 2)
        begin
            svc = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 10))
                                              : 4'($urandom_range(0, 15));
            queue_word(OP_FIND_SVC, svc, 1'($urandom_range(0, 1)),
                       $urandom_range(0, 2047), $urandom_range(0, 4095), drain);
        end
        else
        begin
            if (near_ids.size() != 0 && $urandom_range(0, 9) < 6)
                id = near_ids[$urandom_range(0, near_ids.size() - 1)];
            else
                id = pick_base();
            queue_word(OP_FIND_ID, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       id, $urandom_range(0, 4095), drain);
        end
    endtask

    task automatic check_result(input out_word_t want, input out_word_t got);
        if (want.found !== got.found || want.index !== got.index
            || want.entry_count !== got.entry_count || want.overflow !== got.overflow)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected found=%0d index=%0d count=%0d ovf=%0d,",
                         want.found, want.index, want.entry_count, want.overflow,
                         " got found=%0d index=%0d count=%0d ovf=%0d",
                         got.found, got.index, got.entry_count, got.overflow);
        end
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin : drive
        logic go;
        pending_t p;
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else if (!(start && !taken))
        begin
            go = 1'b0;
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (pending.size() != 0)
            begin
                if (!pending[0].no_gap && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(0, 3);
                else if (!(pending[0].drain && expected.size() != 0))
                begin
                    p = pending.pop_front();
                    cmd <= p.word;
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : watch
        if (rst_n)
        begin
            if (done)
            begin
                if (expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: found=%0d index=%0d count=%0d ovf=%0d",
                                 result.found, result.index, result.entry_count,
                                 result.overflow);
                end
                else
                    check_result(expected.pop_front(), result);
            end
            if (start && !busy)
            begin
                expected.push_back(classify_word(cmd));
                words_taken++;
            end
        end
        taken <= rst_n && start && !busy;
    end

    initial
    begin : stimulus
        int seg_len;
        int app_pct;
        int rand_done;
        load_default_set();

        // directed
        queue_word(OP_FIND_SVC, SVC_NMT, DIR_RX, 0, 0, 1'b0);
        queue_word(OP_FIND_SVC, SVC_LSS, DIR_RX, 2047, 4095, 1'b0);
        queue_word(OP_FIND_SVC, SVC_TOP, DIR_TX, 0, 0, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 0, 0, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 'h0ff, 0, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 'h7ff, 0, 1'b0);
        queue_word(OP_APPEND, SVC_TOP, DIR_RX, 'h7ff, 0, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 'h7ff, 0, 1'b0);
        queue_word(OP_APPEND, 4'd11, DIR_TX, 'h7f0, 4095, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 'h7ff, 0, 1'b0);
        queue_word(OP_FIND_SVC, 4'd11, DIR_TX, 0, 0, 1'b0);
        queue_word(OP_APPEND, 4'd12, DIR_RX, 0, 2048, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 'h790, 0, 1'b0);
        for (int i = 0; i < 12; i++)
            queue_word(OP_APPEND, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 2047), $urandom_range(0, 4095), 1'b0);
        queue_word(OP_APPEND, SVC_SDO, DIR_RX, 'h123, 5, 1'b1);
        queue_word(OP_FIND_SVC, SVC_TOP, DIR_TX, 0, 0, 1'b0);
        queue_word(OP_CLEAR, 0, 0, 0, 0, 1'b0);
        queue_word(OP_FIND_SVC, SVC_NMT, DIR_RX, 0, 0, 1'b0);
        queue_word(OP_APPEND, SVC_NMT, DIR_TX, 'h7ff, 1, 1'b0);
        queue_word(OP_FIND_ID, 0, 0, 'h080, 0, 1'b0);

        // random segments, mostly a clear followed by a fill with searches
        rand_done = 0;
        while (rand_done < RAND_WORDS)
        begin
            seg_len = $urandom_range(8, 80);
            app_pct = $urandom_range(20, 70);
            quiet = ($urandom_range(0, 3) == 0) || (rand_done >= RAND_WORDS - QUIET_TAIL);
            if ($urandom_range(0, 4) != 0)
            begin
                queue_word(OP_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 2047), $urandom_range(0, 4095), 1'b0);
                rand_done++;
            end
            for (int k = 0; k < seg_len && rand_done < RAND_WORDS; k++)
            begin
                if (rand_done >= RAND_WORDS - QUIET_TAIL)
                    quiet = 1'b1;
                queue_random_word(app_pct, ((rand_done % 200) == 199)
                                  && (rand_done < RAND_WORDS - QUIET_TAIL));
                rand_done++;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_taken != words_total || expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
